// ===== src/swept_box_collision_unit_assert.svh =====
// assertion macros for the swept box collision unit
`ifndef SWEPT_BOX_COLLISION_UNIT_ASSERT_SVH
`define SWEPT_BOX_COLLISION_UNIT_ASSERT_SVH

// condition and property checked in the same cycle
`define SCU_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("swept box collision unit: same cycle check failed");

// property checked in the cycle after the condition
`define SCU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("swept box collision unit: next cycle check failed");

`endif

// ===== src/scu_pkg.sv =====
`timescale 1ns / 1ps

package scu_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int HALF_W      = COORD_WIDTH - 1;
    localparam int DIST_W      = COORD_WIDTH + 3;
    localparam int MAG_W       = COORD_WIDTH + 2;
    localparam int QB          = FRAC_BITS + 2;
    localparam int PRE_SHIFT   = QB - FRAC_BITS;
    localparam int OVF_W       = MAG_W + PRE_SHIFT;
    localparam int REM_W       = COORD_WIDTH + 1;
    localparam int STEPS       = 2;
    localparam int DIV_STAGES  = (QB + STEPS - 1) / STEPS;
    localparam int N_STAGES    = DIV_STAGES + 4;
    localparam int T_W         = FRAC_BITS + 3;
    localparam int ENTRY_W     = FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 3;

    localparam int IN_MC_LSB    = 0;
    localparam int IN_OC_LSB    = 3 * COORD_WIDTH;
    localparam int IN_OH_LSB    = 6 * COORD_WIDTH;
    localparam int IN_FIELDS_W  = 6 * COORD_WIDTH + 3 * HALF_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ENTRY_W + 2 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_ENTRY_LSB = 1;
    localparam int OUT_AXIS_LSB  = 1 + ENTRY_W;
    localparam int OUT_NEG_BIT   = 3 + ENTRY_W;

    localparam logic [CFG_IDX_W-1:0] REG_MOVER_HALF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_HALF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVER_HALF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_Z   = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [HALF_W-1:0]             half_t;
    typedef logic signed [DIST_W-1:0]      dist_t;
    typedef logic signed [T_W-1:0]         time_t;

    localparam logic [QB-1:0]      Q_ONE     = QB'(64'd1 << FRAC_BITS);
    localparam time_t              T_ONE     = T_W'(64'd1 << FRAC_BITS);
    localparam time_t              T_OVER    = T_W'((64'd1 << FRAC_BITS) + 64'd1);
    localparam time_t              T_NEG     = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [QB-1:0]          nbits;
        logic [COORD_WIDTH-1:0] den;
        logic [QB-1:0]          q;
        logic                   neg;
        logic                   zero;
        logic                   ovf;
    } div_t;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry_time;
        logic [1:0]         normal_axis;
        logic               normal_negative;
    } result_t;

    function automatic div_t div_step(input div_t d);
        div_t r;
        logic [REM_W-1:0] sh;
        r = d;
        sh = {d.rem[REM_W-2:0], d.nbits[QB-1]};
        r.nbits = d.nbits << 1;
        if (sh >= REM_W'(d.den)) begin
            r.rem = sh - REM_W'(d.den);
            r.q = {d.q[QB-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q = {d.q[QB-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/swept_box_collision_unit.sv =====
`timescale 1ns / 1ps

// Swept box collision test in Q16.16: one obstacle word in, one result word out, one word
// per clock sustained while m_axis_tready does not stall the output. The pipeline depth is
// set by six parallel restoring dividers (entry and exit time per axis), each running
// 18 quotient steps at two steps per pipeline stage, plus two stages ahead for the face
// distances and magnitudes and two behind for clamping and the hit decision.
// Stages only stall where a word is held, so bubbles close up behind a stalled output.

module swept_box_collision_unit
    import scu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mover_center_x/y/z, obstacle_center_x/y/z, obstacle_half_x/y/z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit, entry_time, normal_axis, normal_negative, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    half_t                 mh_reg [3];
    coord_t                vel_reg [3];
    logic [N_STAGES-1:0]   valid_reg;
    logic [2:0]            nn_pipe_reg [DIV_STAGES];
    logic [N_STAGES-1:0]   adv;

    coord_t     mc [3];
    coord_t     oc [3];
    half_t      oh [3];
    div_t       div_in [6];
    div_t       div_out [6];
    logic [2:0] entry_nonneg;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                mh_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MOVER_HALF_X: mh_reg[0] <= cfg_wdata[HALF_W-1:0];
                REG_MOVER_HALF_Y: mh_reg[1] <= cfg_wdata[HALF_W-1:0];
                REG_MOVER_HALF_Z: mh_reg[2] <= cfg_wdata[HALF_W-1:0];
                REG_VELOCITY_X:   vel_reg[0] <= cfg_wdata;
                REG_VELOCITY_Y:   vel_reg[1] <= cfg_wdata;
                REG_VELOCITY_Z:   vel_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mc[i] = s_axis_tdata[IN_MC_LSB + i * COORD_WIDTH +: COORD_WIDTH];
            oc[i] = s_axis_tdata[IN_OC_LSB + i * COORD_WIDTH +: COORD_WIDTH];
            oh[i] = s_axis_tdata[IN_OH_LSB + i * HALF_W +: HALF_W];
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        adv[N_STAGES-1] = !valid_reg[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            nn_pipe_reg[0] <= entry_nonneg;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (adv[k+2]) begin
                nn_pipe_reg[k] <= nn_pipe_reg[k-1];
            end
        end
    end

    scu_front u_front (
        .aclk         (aclk),
        .adv          (adv[1:0]),
        .mc           (mc),
        .oc           (oc),
        .oh           (oh),
        .mh           (mh_reg),
        .vel          (vel_reg),
        .div_in       (div_in),
        .entry_nonneg (entry_nonneg)
    );

    for (genvar d = 0; d < 6; d++) begin : g_div
        scu_divider u_div (
            .aclk (aclk),
            .adv  (adv[DIV_STAGES+1:2]),
            .din  (div_in[d]),
            .dout (div_out[d])
        );
    end

    scu_decide u_decide (
        .aclk         (aclk),
        .adv          (adv[N_STAGES-1:N_STAGES-2]),
        .dq           (div_out),
        .entry_nonneg (nn_pipe_reg[DIV_STAGES-1]),
        .res          (res)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[N_STAGES-1];
    assign m_axis_tdata = OUT_TDATA_W'({res.normal_negative, res.normal_axis,
                                        res.entry_time, res.hit});

endmodule

// ===== src/scu_front.sv =====
`timescale 1ns / 1ps

module scu_front
    import scu_pkg::*;
(
    input  logic       aclk,
    input  logic [1:0] adv,
    input  coord_t     mc [3],
    input  coord_t     oc [3],
    input  half_t      oh [3],
    input  half_t      mh [3],
    input  coord_t     vel [3],
    output div_t       div_in [6],
    output logic [2:0] entry_nonneg
);

    dist_t                  near_reg [3];
    dist_t                  far_reg [3];
    logic [COORD_WIDTH-1:0] vmag_reg [3];
    logic [2:0]             vneg_reg;
    logic [2:0]             vzero_reg;
    div_t                   div_reg [6];
    logic [2:0]             nonneg_reg;

    dist_t                  near_next [3];
    dist_t                  far_next [3];
    logic [COORD_WIDTH-1:0] vmag_next [3];
    div_t                   div_next [6];

    always_comb begin
        dist_t oce, ohe, mce, mhe, lo, hi;
        logic [COORD_WIDTH-1:0] vneg_val;
        for (int i = 0; i < 3; i++) begin
            oce = DIST_W'(oc[i]);
            mce = DIST_W'(mc[i]);
            ohe = signed'(DIST_W'(oh[i]));
            mhe = signed'(DIST_W'(mh[i]));
            lo = (oce - ohe) - (mce + mhe);
            hi = (oce + ohe) - (mce - mhe);
            if (!vel[i][COORD_WIDTH-1] && (vel[i] != '0)) begin
                near_next[i] = lo;
                far_next[i] = hi;
            end else begin
                near_next[i] = hi;
                far_next[i] = lo;
            end
            vneg_val = -vel[i];
            vmag_next[i] = vel[i][COORD_WIDTH-1] ? vneg_val : vel[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                near_reg[i] <= near_next[i];
                far_reg[i] <= far_next[i];
                vmag_reg[i] <= vmag_next[i];
                vneg_reg[i] <= vel[i][COORD_WIDTH-1];
                vzero_reg[i] <= (vel[i] == '0);
            end
        end
    end

    always_comb begin
        dist_t d;
        logic [DIST_W-1:0] dneg;
        logic [MAG_W-1:0] mag;
        for (int k = 0; k < 6; k++) begin
            d = (k < 3) ? near_reg[k % 3] : far_reg[k % 3];
            dneg = -d;
            mag = d[DIST_W-1] ? MAG_W'(dneg) : MAG_W'(d);
            div_next[k].rem = REM_W'(mag >> PRE_SHIFT);
            div_next[k].nbits = {mag[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            div_next[k].den = vmag_reg[k % 3];
            div_next[k].q = '0;
            div_next[k].neg = d[DIST_W-1] ^ vneg_reg[k % 3];
            div_next[k].zero = vzero_reg[k % 3];
            div_next[k].ovf = OVF_W'(mag) >= (OVF_W'(vmag_reg[k % 3]) << PRE_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int k = 0; k < 6; k++) begin
                div_reg[k] <= div_next[k];
            end
            for (int i = 0; i < 3; i++) begin
                nonneg_reg[i] <= !near_reg[i][DIST_W-1];
            end
        end
    end

    assign div_in = div_reg;
    assign entry_nonneg = nonneg_reg;

endmodule

// ===== src/scu_divider.sv =====
`timescale 1ns / 1ps

module scu_divider
    import scu_pkg::*;
(
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] adv,
    input  div_t                  din,
    output div_t                  dout
);

    div_t stage_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        div_t src;
        div_t stage_next;

        if (s == 0) begin : g_first
            assign src = din;
        end else begin : g_rest
            assign src = stage_reg[s-1];
        end

        always_comb begin
            stage_next = src;
            for (int j = 0; j < STEPS; j++) begin
                if (s * STEPS + j < QB) begin
                    stage_next = div_step(stage_next);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                stage_reg[s] <= stage_next;
            end
        end
    end

    assign dout = stage_reg[DIV_STAGES-1];

endmodule

// ===== src/scu_decide.sv =====
`timescale 1ns / 1ps

module scu_decide
    import scu_pkg::*;
(
    input  logic       aclk,
    input  logic [1:0] adv,
    input  div_t       dq [6],
    input  logic [2:0] entry_nonneg,
    output result_t    res
);

    time_t      t_in_reg [3];
    time_t      t_out_reg [3];
    logic [2:0] nn_reg;
    result_t    res_reg;

    time_t      t_in_next [3];
    time_t      t_out_next [3];
    result_t    res_next;

    // negative times and late entries collapse to -1, exit times past 1.0 to just above it
    always_comb begin
        div_t a, b;
        for (int i = 0; i < 3; i++) begin
            a = dq[i];
            b = dq[i + 3];
            if (a.zero) begin
                t_in_next[i] = T_NEG;
            end else if (a.neg) begin
                t_in_next[i] = (a.q == '0 && !a.ovf) ? '0 : T_NEG;
            end else if (a.ovf || a.q > Q_ONE) begin
                t_in_next[i] = T_NEG;
            end else begin
                t_in_next[i] = T_W'(a.q);
            end
            if (b.zero) begin
                t_out_next[i] = T_OVER;
            end else if (b.neg) begin
                t_out_next[i] = (b.q == '0 && !b.ovf) ? '0 : T_NEG;
            end else if (b.ovf || b.q > Q_ONE) begin
                t_out_next[i] = T_OVER;
            end else begin
                t_out_next[i] = T_W'(b.q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            t_in_reg <= t_in_next;
            t_out_reg <= t_out_next;
            nn_reg <= entry_nonneg;
        end
    end

    always_comb begin
        time_t tmax, tmin;
        logic any_nonneg;
        logic [1:0] ax;
        tmax = t_in_reg[0];
        tmin = t_out_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (t_in_reg[i] > tmax) begin
                tmax = t_in_reg[i];
            end
            if (t_out_reg[i] < tmin) begin
                tmin = t_out_reg[i];
            end
        end
        any_nonneg = !t_in_reg[0][T_W-1] || !t_in_reg[1][T_W-1] || !t_in_reg[2][T_W-1];
        if (t_in_reg[0] > t_in_reg[1] && t_in_reg[0] > t_in_reg[2]) begin
            ax = AXIS_X;
        end else if (t_in_reg[1] > t_in_reg[0] && t_in_reg[1] > t_in_reg[2]) begin
            ax = AXIS_Y;
        end else begin
            ax = AXIS_Z;
        end
        if (any_nonneg && !(tmax > tmin)) begin
            res_next.hit = 1'b1;
            res_next.entry_time = ENTRY_W'(tmax);
            res_next.normal_axis = ax;
            res_next.normal_negative = nn_reg[ax];
        end else begin
            res_next.hit = 1'b0;
            res_next.entry_time = ENTRY_ONE;
            res_next.normal_axis = AXIS_X;
            res_next.normal_negative = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== src/scu_checker.sv =====
`timescale 1ns / 1ps
`include "swept_box_collision_unit_assert.svh"

module scu_checker
    import scu_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic               hit;
    logic [ENTRY_W-1:0] entry;
    logic [1:0]         axis_code;
    logic               neg;
    logic               miss_ok;
    logic               axis_ok;

    assign hit = m_axis_tdata[0];
    assign entry = m_axis_tdata[OUT_ENTRY_LSB +: ENTRY_W];
    assign axis_code = m_axis_tdata[OUT_AXIS_LSB +: 2];
    assign neg = m_axis_tdata[OUT_NEG_BIT];

    assign miss_ok = (entry == ENTRY_ONE) && (axis_code == AXIS_X) && !neg;
    assign axis_ok = (axis_code == AXIS_X) || (axis_code == AXIS_Y) || (axis_code == AXIS_Z);

    `SCU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SCU_ASSERT_SAME(a_miss_fields, aclk, aresetn, m_axis_tvalid && !hit, miss_ok)
    `SCU_ASSERT_SAME(a_hit_time, aclk, aresetn, m_axis_tvalid && hit, entry <= ENTRY_ONE)
    `SCU_ASSERT_SAME(a_hit_axis, aclk, aresetn, m_axis_tvalid && hit, axis_ok)

endmodule

bind swept_box_collision_unit scu_checker u_scu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/swept_box_checker.sv =====
`timescale 1ns / 1ps

module swept_box_checker
    import scu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_wdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam longint NEG_INF = 64'sh8000_0000_0000_0000;
    localparam longint POS_INF = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SAT_MAG = (64'sd1 <<< 62) - 1;
    localparam longint ONE     = 64'sd1 <<< FRAC_BITS;

    half_t  box_half [3];
    coord_t box_vel  [3];
    logic [OUT_TDATA_W-1:0] contact_q [$];

    // (num << FRAC_BITS) / den, toward zero, saturated
    function automatic longint time_div(longint num, longint den);
        bit neg;
        longint un, ud, q, r, mag;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        if (q > (SAT_MAG >>> FRAC_BITS)) begin
            mag = SAT_MAG;
        end else begin
            mag = q <<< FRAC_BITS;
            for (int i = FRAC_BITS - 1; i >= 0; i--) begin
                r = r <<< 1;
                if (r >= ud) begin
                    r = r - ud;
                    mag = mag | (64'sd1 <<< i);
                end
            end
        end
        return neg ? -mag : mag;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] predict_contact(logic [IN_TDATA_W-1:0] w);
        longint mc, oc, oh, mh, v, nd, fd, te, tl;
        longint t_in [3];
        longint t_out [3];
        longint e_dist [3];
        bit all_neg;
        logic [1:0] ax;
        logic [OUT_TDATA_W-1:0] res;
        all_neg = 1;
        for (int i = 0; i < 3; i++) begin
            mc = coord_t'(w[IN_MC_LSB + COORD_WIDTH*i +: COORD_WIDTH]);
            oc = coord_t'(w[IN_OC_LSB + COORD_WIDTH*i +: COORD_WIDTH]);
            oh = longint'({1'b0, w[IN_OH_LSB + HALF_W*i +: HALF_W]});
            mh = longint'({1'b0, box_half[i]});
            v  = box_vel[i];
            if (v > 0) begin
                nd = (oc - oh) - (mc + mh);
                fd = (oc + oh) - (mc - mh);
            end else begin
                nd = (oc + oh) - (mc - mh);
                fd = (oc - oh) - (mc + mh);
            end
            e_dist[i] = nd;
            if (v == 0) begin
                t_in[i] = NEG_INF;
                t_out[i] = POS_INF;
            end else begin
                t_in[i] = time_div(nd, v);
                t_out[i] = time_div(fd, v);
            end
            if (t_in[i] > ONE) t_in[i] = NEG_INF;
            if (t_in[i] >= 0) all_neg = 0;
        end
        te = t_in[0];
        tl = t_out[0];
        for (int i = 1; i < 3; i++) begin
            if (t_in[i] > te) te = t_in[i];
            if (t_out[i] < tl) tl = t_out[i];
        end
        res = '0;
        if (te > tl || all_neg) begin
            res[OUT_ENTRY_LSB +: ENTRY_W] = ENTRY_ONE;
            return res;
        end
        if (t_in[0] > t_in[1] && t_in[0] > t_in[2]) ax = AXIS_X;
        else if (t_in[1] > t_in[0] && t_in[1] > t_in[2]) ax = AXIS_Y;
        else ax = AXIS_Z;
        res[0] = 1'b1;
        res[OUT_ENTRY_LSB +: ENTRY_W] = te[ENTRY_W-1:0];
        res[OUT_AXIS_LSB +: 2] = ax;
        res[OUT_NEG_BIT] = e_dist[ax] >= 0;
        return res;
    endfunction

    assign pending = contact_q.size();

    always @(posedge aclk) begin
        logic [OUT_TDATA_W-1:0] exp_w;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_half[i] <= '0;
                box_vel[i] <= '0;
            end
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MOVER_HALF_X: box_half[0] <= cfg_wdata[HALF_W-1:0];
                    REG_MOVER_HALF_Y: box_half[1] <= cfg_wdata[HALF_W-1:0];
                    REG_MOVER_HALF_Z: box_half[2] <= cfg_wdata[HALF_W-1:0];
                    REG_VELOCITY_X:   box_vel[0] <= cfg_wdata;
                    REG_VELOCITY_Y:   box_vel[1] <= cfg_wdata;
                    REG_VELOCITY_Z:   box_vel[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                contact_q.push_back(predict_contact(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (contact_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = contact_q.pop_front();
                    if (exp_w[0] !== m_axis_tdata[0]
                        || exp_w[OUT_ENTRY_LSB +: ENTRY_W]
                           !== m_axis_tdata[OUT_ENTRY_LSB +: ENTRY_W]
                        || exp_w[OUT_AXIS_LSB +: 2] !== m_axis_tdata[OUT_AXIS_LSB +: 2]
                        || exp_w[OUT_NEG_BIT] !== m_axis_tdata[OUT_NEG_BIT]) begin
                        if (fail_count < 10)
                            $display("mismatch: hit %b/%b entry %0d/%0d axis %0d/%0d neg %b/%b",
                                exp_w[0], m_axis_tdata[0],
                                exp_w[OUT_ENTRY_LSB +: ENTRY_W],
                                m_axis_tdata[OUT_ENTRY_LSB +: ENTRY_W],
                                exp_w[OUT_AXIS_LSB +: 2], m_axis_tdata[OUT_AXIS_LSB +: 2],
                                exp_w[OUT_NEG_BIT], m_axis_tdata[OUT_NEG_BIT]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import scu_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_WIDTH-1:0] cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     fail_count;
    int                     pending;

    bit     no_idle = 0;
    bit     hold_req = 0;
    longint cur_vel [3];
    longint cur_half [3];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    swept_box_collision_unit dut (.*);
    swept_box_checker chk (.*);

    initial begin
        #3ms;
        $display("tb failed");
        $finish;
    end

    // receiver: random hold-off per word, one long hold on request
    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                n = 400;
                hold_req = 0;
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[COORD_WIDTH-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_motion(longint hx, longint hy, longint hz,
                              longint vx, longint vy, longint vz);
        cur_half[0] = hx; cur_half[1] = hy; cur_half[2] = hz;
        cur_vel[0] = vx; cur_vel[1] = vy; cur_vel[2] = vz;
        write_reg(REG_MOVER_HALF_X, hx);
        write_reg(REG_MOVER_HALF_Y, hy);
        write_reg(REG_MOVER_HALF_Z, hz);
        write_reg(REG_VELOCITY_X, vx);
        write_reg(REG_VELOCITY_Y, vy);
        write_reg(REG_VELOCITY_Z, vz);
    endtask

    task automatic send_word(logic [IN_TDATA_W-1:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_box(longint mc [3], longint oc [3],
                                                       longint oh [3]);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < 3; i++) begin
            w[IN_MC_LSB + COORD_WIDTH*i +: COORD_WIDTH] = mc[i][COORD_WIDTH-1:0];
            w[IN_OC_LSB + COORD_WIDTH*i +: COORD_WIDTH] = oc[i][COORD_WIDTH-1:0];
            w[IN_OH_LSB + HALF_W*i +: HALF_W] = oh[i][HALF_W-1:0];
        end
        return w;
    endfunction

    // obstacle placed along the sweep with jitter, or plain noise
    function automatic logic [IN_TDATA_W-1:0] random_scene();
        longint mc [3];
        longint oc [3];
        longint oh [3];
        longint f;
        logic [IN_TDATA_W-1:0] w;
        if ($urandom_range(0, 9) < 2) begin
            for (int i = 0; i < IN_TDATA_W / 32; i++) w[32*i +: 32] = $urandom;
            return w;
        end
        f = $urandom_range(0, 85000);
        for (int i = 0; i < 3; i++) begin
            mc[i] = longint'($signed($urandom)) >>> $urandom_range(6, 12);
            oh[i] = $urandom_range(0, 1 << 20);
            oc[i] = mc[i] + ((cur_vel[i] * f) >>> FRAC_BITS)
                    + longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
            if ($urandom_range(0, 3) == 0) oc[i] = mc[i] + (cur_half[i] + oh[i]);
        end
        return pack_box(mc, oc, oh);
    endfunction

    function automatic longint random_vel();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 64'sh7fff_ffff;
            2: return -64'sh8000_0000;
            default: return longint'($signed($urandom_range(0, 1 << 23))) - (1 << 22);
        endcase
    endfunction

    initial begin
        longint mc [3];
        longint oc [3];
        longint oh [3];
        longint ext [4];
        ext[0] = -64'sh8000_0000; ext[1] = 64'sh7fff_ffff; ext[2] = 0; ext[3] = -1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: all velocities zero
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                mc[i] = ext[k]; oc[i] = ext[3-k]; oh[i] = k[0] ? 64'h7fff_ffff : 0;
            end
            send_word(pack_box(mc, oc, oh));
        end
        wait_drain();

        set_motion(64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff,
                   64'sh7fff_ffff, -64'sh8000_0000, 64'sh7fff_ffff);
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                mc[i] = ext[(k + i) % 4]; oc[i] = ext[(k + 2*i + 1) % 4];
                oh[i] = k[1] ? 64'h7fff_ffff : 0;
            end
            send_word(pack_box(mc, oc, oh));
        end
        wait_drain();

        // face contact, ties, entry at one
        set_motion(65536, 65536, 65536, 65536 * 4, 65536 * 4, 0);
        for (int k = 0; k < 10; k++) begin
            mc[0] = 0; mc[1] = 0; mc[2] = 0;
            oh[0] = 65536; oh[1] = 65536; oh[2] = 65536;
            oc[0] = 65536 * (2 + k / 2); oc[1] = (k % 2) ? oc[0] : 65536 * 3; oc[2] = 0;
            send_word(pack_box(mc, oc, oh));
        end
        wait_drain();

        for (int p = 0; p < 10; p++) begin
            if (p == 0)
                set_motion(0, 0, 0, 0, 0, 0);
            else if (p == 1)
                set_motion(64'h7fff_ffff, 0, 64'h7fff_ffff,
                           -64'sh8000_0000, 64'sh7fff_ffff, 0);
            else
                set_motion($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21),
                           $urandom_range(0, 1 << 21), random_vel(), random_vel(), random_vel());
            no_idle = (p % 4 == 3);
            if (p == 5) hold_req = 1;
            for (int n = 0; n < 192; n++) send_word(random_scene());
            wait_drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
